>>> hw/rtl/wfrlm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfrlm_pkg
// Types, constants and helper functions of the windowed frame-rate and
// latency monitor.
// ----------------------------------------------------------------------------
package wfrlm_pkg;

  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned LATENCY_BITS   = 32;
  localparam int unsigned FRACTION_BITS  = 8;
  localparam int unsigned SUM_BITS       = 48;
  localparam int unsigned TIME_BITS      = 63;
  localparam int unsigned WINDOW_BITS    = 40;
  localparam int unsigned NS_BITS        = 30;
  localparam int unsigned RATE_BITS      = 24;
  localparam int unsigned DROP_BITS      = 17;
  localparam int unsigned DROP_SHIFT     = 16;
  localparam int unsigned AVG_BITS       = 32;
  localparam int unsigned CONTOUR_BITS   = 40;
  localparam int unsigned ADDR_BITS      = 4;
  localparam int unsigned DATA_BITS      = 64;

  localparam logic [NS_BITS-1:0]     NS_PER_S     = 30'd1000000000;
  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 40'd1000000000;

  localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;

  localparam logic [2:0] KIND_RECEIVED  = 3'd0;
  localparam logic [2:0] KIND_PROCESSED = 3'd1;
  localparam logic [2:0] KIND_DISPLAYED = 3'd2;
  localparam logic [2:0] KIND_QUERY     = 3'd3;
  localparam logic [2:0] KIND_CLEAR     = 3'd4;

  typedef struct packed {
    logic [2:0]           kind;
    logic [TIME_BITS-1:0] event_time;
    logic [31:0]          contour_size;
    logic [TIME_BITS-1:0] receive_stamp;
    logic [TIME_BITS-1:0] process_stamp;
    logic [TIME_BITS-1:0] display_stamp;
  } in_t;

  typedef struct packed {
    logic [RATE_BITS-1:0]    received_rate;
    logic [RATE_BITS-1:0]    processed_rate;
    logic [RATE_BITS-1:0]    displayed_rate;
    logic [DROP_BITS-1:0]    drop_fraction;
    logic [AVG_BITS-1:0]     avg_display_latency;
    logic [AVG_BITS-1:0]     max_display_latency;
    logic [AVG_BITS-1:0]     avg_process_latency;
    logic [CONTOUR_BITS-1:0] avg_contour;
    logic                    window_closed;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ACCUM,
    ST_LOAD,
    ST_DIV,
    ST_STORE,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    OP_RX_RATE,
    OP_PX_RATE,
    OP_DX_RATE,
    OP_DROP,
    OP_AVG_DISP,
    OP_AVG_PROC,
    OP_AVG_CONT
  } op_e;

  function automatic logic [LATENCY_BITS-1:0] stamp_diff(
    input logic [TIME_BITS-1:0] later,
    input logic [TIME_BITS-1:0] earlier
  );
    logic [TIME_BITS-1:0] d;
    d = (later > earlier) ? later - earlier : '0;
    if (d > TIME_BITS'({LATENCY_BITS{1'b1}})) begin
      return {LATENCY_BITS{1'b1}};
    end
    return d[LATENCY_BITS-1:0];
  endfunction

  function automatic logic [SUM_BITS-1:0] sat_sum(
    input logic [SUM_BITS-1:0] a,
    input logic [SUM_BITS-1:0] b
  );
    logic [SUM_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
  endfunction

endpackage

>>> hw/rtl/windowed_frame_rate_latency_monitor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_frame_rate_latency_monitor_unit
// Frame statistics over a time window with one shared restoring divider.
// ----------------------------------------------------------------------------
// Input beats carry one frame event (received, processed, displayed, query,
// clear); every event gives exactly one output beat holding the current
// snapshot and a flag that tells whether this event closed the window.
// The APB port holds the window length at byte address 0 (64-bit data).
// An event that does not close the window passes through PREP, ACCUM and
// DONE before output valid is set. A closing event runs seven divisions
// through one divider that resolves one quotient bit a cycle; each loads
// in LOAD, steps in DIV and stores in STORE, and skips DIV when its result
// is zero by rule: a zero divisor count, or no dropped frames.
// in_ready_o is high only while no event is being worked on; one finished
// beat waits in the output register, so the next event is taken while the
// receiver stalls, and it then holds at its end until the output frees.
// Reset clears counts, sums, peak, window start and snapshot and loads a
// window length of one second.
// ----------------------------------------------------------------------------
module windowed_frame_rate_latency_monitor_unit #(
  parameter int unsigned COUNT_BITS = wfrlm_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  wfrlm_pkg::in_t                      in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output wfrlm_pkg::out_t                     out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wfrlm_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [wfrlm_pkg::DATA_BITS-1:0]     pwdata,
  output logic [wfrlm_pkg::DATA_BITS-1:0]     prdata,
  output logic                                pready
);
  import wfrlm_pkg::*;

  localparam int unsigned PROD_W   = COUNT_BITS + NS_BITS;
  localparam int unsigned RATE_LEN = PROD_W + FRACTION_BITS;
  localparam int unsigned CONT_LEN = SUM_BITS + FRACTION_BITS;
  localparam int unsigned DROP_LEN = COUNT_BITS + DROP_SHIFT;
  localparam int unsigned DIV_W    = (RATE_LEN > CONT_LEN) ? RATE_LEN : CONT_LEN;
  localparam int unsigned IDX_W    = $clog2(DIV_W);

  state_e                   state_q, state_d;
  op_e                      op_q;
  in_t                      item_q;
  logic [WINDOW_BITS-1:0]   wlen_q;
  logic [COUNT_BITS-1:0]    rx_cnt_q, px_cnt_q, dx_cnt_q;
  logic [SUM_BITS-1:0]      cont_sum_q, dlat_sum_q, plat_sum_q;
  logic [AVG_BITS-1:0]      peak_q;
  logic [TIME_BITS-1:0]     start_q;
  out_t                     snap_q;
  logic                     close_q;
  logic [LATENCY_BITS-1:0]  dl_q, pl_q;
  logic [TIME_BITS-1:0]     elapsed_q;
  logic [DIV_W-1:0]         dvd_q;
  logic [TIME_BITS-1:0]     dvs_q, rem_q;
  logic [CONTOUR_BITS-1:0]  quo_q;
  logic                     ovf_q;
  logic [IDX_W-1:0]         idx_q, lim_q;
  out_t                     out_q;
  logic                     out_valid_q;

  logic in_fire, prep_en, accum_en, load_en, step_en, store_en, done_en, cfg_wr;
  logic close_now;
  logic [WINDOW_BITS-1:0] wlen_eff;
  logic [SUM_BITS-1:0]    dl_w;

  logic [COUNT_BITS-1:0]  cnt_sel;
  logic [PROD_W-1:0]      prod;
  logic [DIV_W-1:0]       load_dvd;
  logic [TIME_BITS-1:0]   load_dvs;
  logic [IDX_W-1:0]       load_idx, load_lim;
  logic                   load_skip;

  logic [TIME_BITS:0]     rem_sh;
  logic [TIME_BITS+1:0]   diff;
  logic                   q_bit;
  op_e                    op_next;

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_BITS-1] == REG_WINDOW_LENGTH);

  always_comb begin
    unique case (paddr[ADDR_BITS-1])
      REG_WINDOW_LENGTH: prdata = DATA_BITS'(wlen_q);
      default:           prdata = '0;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_PREP;
      ST_PREP:  state_d = ST_ACCUM;
      ST_ACCUM: state_d = close_now ? ST_LOAD : ST_DONE;
      ST_LOAD:  state_d = load_skip ? ST_STORE : ST_DIV;
      ST_DIV:   if (idx_q == '0) state_d = ST_STORE;
      ST_STORE: state_d = (op_q == OP_AVG_CONT) ? ST_DONE : ST_LOAD;
      ST_DONE:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    in_fire    = (state_q == ST_IDLE) && in_valid_i;
    prep_en    = (state_q == ST_PREP);
    accum_en   = (state_q == ST_ACCUM);
    load_en    = (state_q == ST_LOAD);
    step_en    = (state_q == ST_DIV);
    store_en   = (state_q == ST_STORE);
    done_en    = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  end

  assign wlen_eff  = (wlen_q == '0) ? WINDOW_BITS'(1) : wlen_q;
  assign close_now = ((item_q.kind == KIND_RECEIVED) || (item_q.kind == KIND_DISPLAYED)) &&
                     (elapsed_q >= TIME_BITS'(wlen_eff));
  assign dl_w      = SUM_BITS'(dl_q);

  // Operand selection for the divider
  always_comb begin
    unique case (op_q)
      OP_RX_RATE: cnt_sel = rx_cnt_q;
      OP_PX_RATE: cnt_sel = px_cnt_q;
      default:    cnt_sel = dx_cnt_q;
    endcase
  end

  assign prod = PROD_W'(cnt_sel) * PROD_W'(NS_PER_S);

  always_comb begin
    load_dvd  = DIV_W'(prod) << (DIV_W - PROD_W);
    load_dvs  = elapsed_q;
    load_idx  = IDX_W'(RATE_LEN - 1);
    load_lim  = IDX_W'(RATE_BITS);
    load_skip = 1'b0;
    unique case (op_q)
      OP_RX_RATE, OP_PX_RATE, OP_DX_RATE: begin
      end
      OP_DROP: begin
        load_dvd  = DIV_W'(rx_cnt_q - dx_cnt_q) << (DIV_W - COUNT_BITS);
        load_dvs  = TIME_BITS'(rx_cnt_q);
        load_idx  = IDX_W'(DROP_LEN - 1);
        load_lim  = IDX_W'(DROP_BITS);
        load_skip = (rx_cnt_q == '0) || (rx_cnt_q <= dx_cnt_q);
      end
      OP_AVG_DISP: begin
        load_dvd  = DIV_W'(dlat_sum_q) << (DIV_W - SUM_BITS);
        load_dvs  = TIME_BITS'(dx_cnt_q);
        load_idx  = IDX_W'(SUM_BITS - 1);
        load_lim  = IDX_W'(AVG_BITS);
        load_skip = (dx_cnt_q == '0);
      end
      OP_AVG_PROC: begin
        load_dvd  = DIV_W'(plat_sum_q) << (DIV_W - SUM_BITS);
        load_dvs  = TIME_BITS'(dx_cnt_q);
        load_idx  = IDX_W'(SUM_BITS - 1);
        load_lim  = IDX_W'(AVG_BITS);
        load_skip = (dx_cnt_q == '0);
      end
      OP_AVG_CONT: begin
        load_dvd  = DIV_W'(cont_sum_q) << (DIV_W - SUM_BITS);
        load_dvs  = TIME_BITS'(px_cnt_q);
        load_idx  = IDX_W'(CONT_LEN - 1);
        load_lim  = IDX_W'(CONTOUR_BITS);
        load_skip = (px_cnt_q == '0);
      end
      default: begin
        load_skip = 1'b1;
      end
    endcase
  end

  // Restoring divider step
  assign rem_sh = {rem_q, dvd_q[DIV_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign q_bit  = !diff[TIME_BITS+1];

  always_comb begin
    unique case (op_q)
      OP_RX_RATE:  op_next = OP_PX_RATE;
      OP_PX_RATE:  op_next = OP_DX_RATE;
      OP_DX_RATE:  op_next = OP_DROP;
      OP_DROP:     op_next = OP_AVG_DISP;
      OP_AVG_DISP: op_next = OP_AVG_PROC;
      OP_AVG_PROC: op_next = OP_AVG_CONT;
      default:     op_next = OP_AVG_CONT;
    endcase
  end

  // Control and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_RX_RATE;
      wlen_q      <= WINDOW_RESET;
      rx_cnt_q    <= '0;
      px_cnt_q    <= '0;
      dx_cnt_q    <= '0;
      cont_sum_q  <= '0;
      dlat_sum_q  <= '0;
      plat_sum_q  <= '0;
      peak_q      <= '0;
      start_q     <= '0;
      snap_q      <= '0;
      close_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        wlen_q <= pwdata[WINDOW_BITS-1:0];
      end
      if (accum_en) begin
        close_q <= close_now;
        op_q    <= OP_RX_RATE;
        unique case (item_q.kind)
          KIND_RECEIVED: begin
            if (rx_cnt_q != '1) rx_cnt_q <= rx_cnt_q + 1'b1;
          end
          KIND_PROCESSED: begin
            if (px_cnt_q != '1) px_cnt_q <= px_cnt_q + 1'b1;
            cont_sum_q <= sat_sum(cont_sum_q, SUM_BITS'(item_q.contour_size));
          end
          KIND_DISPLAYED: begin
            if (dx_cnt_q != '1) dx_cnt_q <= dx_cnt_q + 1'b1;
            dlat_sum_q <= sat_sum(dlat_sum_q, dl_w);
            plat_sum_q <= sat_sum(plat_sum_q, SUM_BITS'(pl_q));
            if (dl_w > SUM_BITS'(peak_q)) begin
              peak_q <= (dl_w > SUM_BITS'({AVG_BITS{1'b1}})) ? '1 : AVG_BITS'(dl_q);
            end
          end
          KIND_CLEAR: begin
            rx_cnt_q   <= '0;
            px_cnt_q   <= '0;
            dx_cnt_q   <= '0;
            cont_sum_q <= '0;
            dlat_sum_q <= '0;
            plat_sum_q <= '0;
            peak_q     <= '0;
            snap_q     <= '0;
            start_q    <= item_q.event_time;
          end
          default: begin
          end
        endcase
      end
      if (store_en) begin
        op_q <= op_next;
        unique case (op_q)
          OP_RX_RATE:  snap_q.received_rate  <= ovf_q ? '1 : quo_q[RATE_BITS-1:0];
          OP_PX_RATE:  snap_q.processed_rate <= ovf_q ? '1 : quo_q[RATE_BITS-1:0];
          OP_DX_RATE:  snap_q.displayed_rate <= ovf_q ? '1 : quo_q[RATE_BITS-1:0];
          OP_DROP:     snap_q.drop_fraction  <= ovf_q ? '1 : quo_q[DROP_BITS-1:0];
          OP_AVG_DISP: snap_q.avg_display_latency <= ovf_q ? '1 : quo_q[AVG_BITS-1:0];
          OP_AVG_PROC: snap_q.avg_process_latency <= ovf_q ? '1 : quo_q[AVG_BITS-1:0];
          default: begin
            snap_q.avg_contour         <= ovf_q ? '1 : quo_q;
            snap_q.max_display_latency <= peak_q;
            rx_cnt_q   <= '0;
            px_cnt_q   <= '0;
            dx_cnt_q   <= '0;
            cont_sum_q <= '0;
            dlat_sum_q <= '0;
            plat_sum_q <= '0;
            peak_q     <= '0;
            start_q    <= item_q.event_time;
          end
        endcase
      end
      if (done_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
    if (prep_en) begin
      dl_q      <= stamp_diff(item_q.display_stamp, item_q.receive_stamp);
      pl_q      <= stamp_diff(item_q.process_stamp, item_q.receive_stamp);
      elapsed_q <= (item_q.event_time > start_q) ? item_q.event_time - start_q : '0;
    end
    if (load_en) begin
      dvd_q <= load_dvd;
      dvs_q <= load_dvs;
      idx_q <= load_idx;
      lim_q <= load_lim;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end
    if (step_en) begin
      rem_q <= q_bit ? diff[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
      dvd_q <= dvd_q << 1;
      quo_q <= {quo_q[CONTOUR_BITS-2:0], q_bit};
      ovf_q <= ovf_q || (q_bit && (idx_q >= lim_q));
      idx_q <= idx_q - 1'b1;
    end
    if (done_en) begin
      out_q <= {snap_q[$bits(out_t)-1:1], close_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
